// ===== sv/cli_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cli_pkg;

    // Register indexes on the configuration port (byte address is 4 * index)
    localparam int unsigned CFG_ADDR_W = 4;
    localparam logic [1:0] REG_HOIST_LIMIT   = 2'd0;
    localparam logic [1:0] REG_TROLLEY_LIMIT = 2'd1;
    localparam logic [1:0] REG_DESCENT_THR   = 2'd2;

    localparam logic [15:0] HOIST_LIMIT_RST   = 16'hFFFF;
    localparam logic [15:0] TROLLEY_LIMIT_RST = 16'hFFFF;
    localparam logic [15:0] DESCENT_THR_RST   = 16'h0000;

    // Controller word value that means "asserted"
    localparam logic [15:0] WORD_ONE = 16'd1;

    typedef enum logic [1:0] {
        SESS_IDLE       = 2'd0,
        SESS_DETECT     = 2'd1,
        SESS_LOCK_ALARM = 2'd2,
        SESS_LOCK_PLATE = 2'd3
    } sess_state_t;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_BEGIN    = 2'd1,
        EV_END_KEEP = 2'd2,
        EV_END_DROP = 2'd3
    } sess_event_t;

    typedef enum logic [1:0] {
        ALM_NONE      = 2'd0,
        ALM_LIFTED    = 2'd1,
        ALM_DROVE     = 2'd2,
        ALM_SYS_ERROR = 2'd3
    } alarm_t;

    typedef struct packed {
        logic [15:0]        hoist_limit;
        logic [15:0]        trolley_limit;
        logic signed [15:0] descent_thr;
    } cli_cfg_t;

    // Decoded snapshot conditions shared by both camera machines
    typedef struct packed {
        logic landed_one;
        logic landed_zero;
        logic in_zone;
        logic out_hoist;
        logic descending;
        logic lock_one;
        logic reset_one;
    } cli_snap_t;

endpackage

`default_nettype wire

// ===== sv/crane_lift_session_interlock.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Crane lift session interlock. Each controller snapshot transfer on the s_
// channel produces exactly one result transfer on the m_ channel, in order.
// A snapshot is first captured in an input register; once the output register
// is free, it is decoded against the configuration registers, both camera
// session machines are stepped and the result is loaded into the output
// register. The block sustains one snapshot per clock cycle while the
// consumer takes each result as it is offered; the only limit on rate is
// the output register, which frees when the consumer takes its result.
// A new snapshot is accepted while a finished result still waits, as long as
// the input register is empty, or is moving on as that result is taken.
// The registers (hoist limit at 0x0, trolley limit at 0x4, signed descent
// speed threshold at 0x8) are written over the APB-style port and should be
// changed only while no snapshot is in flight.

module crane_lift_session_interlock
    import cli_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // Snapshot channel
    input  wire logic                  s_valid,
    output      logic                  s_ready,
    input  wire logic [15:0]           s_trolley_position,
    input  wire logic [15:0]           s_hoist_height,
    input  wire logic signed [15:0]    s_hoist_speed,
    input  wire logic [15:0]           s_lock_word,
    input  wire logic [15:0]           s_landed_word,
    input  wire logic [15:0]           s_reset_word,
    input  wire logic [1:0]            s_cam0_alarm_report,
    input  wire logic                  s_cam0_plate_seen,
    input  wire logic [1:0]            s_cam1_alarm_report,
    input  wire logic                  s_cam1_plate_seen,

    // Result channel
    output      logic                  m_valid,
    input  wire logic                  m_ready,
    output      logic [1:0]            m_worst_alarm,
    output      logic [1:0]            m_cam0_session,
    output      logic [1:0]            m_cam1_session,
    output      logic [1:0]            m_cam0_event,
    output      logic [1:0]            m_cam1_event,
    output      logic [1:0]            m_cam0_alarm,
    output      logic [1:0]            m_cam1_alarm,

    // Configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output      logic [31:0]           prdata,
    output      logic                  pready
);

    cli_cfg_t cfg;

    cli_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register stage. Payload registers carry no reset; only the
    // valid flag is cleared.
    logic               in_valid_reg;
    logic [15:0]        trolley_reg;
    logic [15:0]        hoist_reg;
    logic signed [15:0] speed_reg;
    logic [15:0]        lock_reg;
    logic [15:0]        landed_reg;
    logic [15:0]        rst_word_reg;
    logic [1:0]         cam0_report_reg;
    logic               cam0_plate_reg;
    logic [1:0]         cam1_report_reg;
    logic               cam1_plate_reg;

    logic out_free;
    logic step;
    logic s_take;

    // The output register can load when it is empty or its result is being
    // taken in this cycle; the input register then hands its snapshot on.
    assign out_free = !m_valid || m_ready;
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign s_take   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_take) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            trolley_reg     <= s_trolley_position;
            hoist_reg       <= s_hoist_height;
            speed_reg       <= s_hoist_speed;
            lock_reg        <= s_lock_word;
            landed_reg      <= s_landed_word;
            rst_word_reg    <= s_reset_word;
            cam0_report_reg <= s_cam0_alarm_report;
            cam0_plate_reg  <= s_cam0_plate_seen;
            cam1_report_reg <= s_cam1_alarm_report;
            cam1_plate_reg  <= s_cam1_plate_seen;
        end
    end

    // Snapshot decode. The zone needs both the hoist below its limit and the
    // trolley below its limit; leaving the zone is judged on the hoist alone.
    cli_snap_t snap;

    always_comb begin
        snap.landed_one  = (landed_reg == WORD_ONE);
        snap.landed_zero = (landed_reg == 16'd0);
        snap.out_hoist   = (hoist_reg >= cfg.hoist_limit);
        snap.in_zone     = !snap.out_hoist && (trolley_reg < cfg.trolley_limit);
        snap.descending  = (speed_reg < cfg.descent_thr);
        snap.lock_one    = (lock_reg == WORD_ONE);
        snap.reset_one   = (rst_word_reg == WORD_ONE);
    end

    // One session machine per camera, each stepped once per snapshot.
    sess_state_t cam0_state_next;
    sess_state_t cam1_state_next;
    sess_event_t cam0_event;
    sess_event_t cam1_event;
    alarm_t      cam0_alarm_next;
    alarm_t      cam1_alarm_next;

    cli_session_cam u_cam0 (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .snap         (snap),
        .alarm_report (cam0_report_reg),
        .plate_seen   (cam0_plate_reg),
        .state_next   (cam0_state_next),
        .event_code   (cam0_event),
        .alarm_next   (cam0_alarm_next)
    );

    cli_session_cam u_cam1 (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .snap         (snap),
        .alarm_report (cam1_report_reg),
        .plate_seen   (cam1_plate_reg),
        .state_next   (cam1_state_next),
        .event_code   (cam1_event),
        .alarm_next   (cam1_alarm_next)
    );

    // Worst alarm is the larger of the two held alarm codes after this step.
    logic [1:0] worst_next;
    assign worst_next = (cam0_alarm_next > cam1_alarm_next) ? cam0_alarm_next
                                                            : cam1_alarm_next;

    // Output register stage
    logic       out_valid_reg;
    logic [1:0] worst_reg;
    logic [1:0] cam0_session_reg;
    logic [1:0] cam1_session_reg;
    logic [1:0] cam0_event_reg;
    logic [1:0] cam1_event_reg;
    logic [1:0] cam0_alarm_reg;
    logic [1:0] cam1_alarm_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            worst_reg        <= worst_next;
            cam0_session_reg <= cam0_state_next;
            cam1_session_reg <= cam1_state_next;
            cam0_event_reg   <= cam0_event;
            cam1_event_reg   <= cam1_event;
            cam0_alarm_reg   <= cam0_alarm_next;
            cam1_alarm_reg   <= cam1_alarm_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_worst_alarm  = worst_reg;
    assign m_cam0_session = cam0_session_reg;
    assign m_cam1_session = cam1_session_reg;
    assign m_cam0_event   = cam0_event_reg;
    assign m_cam1_event   = cam1_event_reg;
    assign m_cam0_alarm   = cam0_alarm_reg;
    assign m_cam1_alarm   = cam1_alarm_reg;

endmodule

`default_nettype wire

// ===== sv/cli_apb_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cli_apb_regs
    import cli_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output      logic [31:0]           prdata,
    output      logic                  pready,
    output      cli_cfg_t              cfg
);

    logic [15:0] hoist_limit_reg;
    logic [15:0] trolley_limit_reg;
    logic [15:0] descent_thr_reg;
    logic [1:0]  reg_idx;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hoist_limit_reg   <= HOIST_LIMIT_RST;
            trolley_limit_reg <= TROLLEY_LIMIT_RST;
            descent_thr_reg   <= DESCENT_THR_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_HOIST_LIMIT:   hoist_limit_reg   <= pwdata[15:0];
                REG_TROLLEY_LIMIT: trolley_limit_reg <= pwdata[15:0];
                REG_DESCENT_THR:   descent_thr_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // The threshold reads back sign-extended, as it is held
    always_comb begin
        case (reg_idx)
            REG_HOIST_LIMIT:   prdata = {16'd0, hoist_limit_reg};
            REG_TROLLEY_LIMIT: prdata = {16'd0, trolley_limit_reg};
            REG_DESCENT_THR:   prdata = {{16{descent_thr_reg[15]}}, descent_thr_reg};
            default:           prdata = 32'd0;
        endcase
    end

    assign cfg.hoist_limit   = hoist_limit_reg;
    assign cfg.trolley_limit = trolley_limit_reg;
    assign cfg.descent_thr   = $signed(descent_thr_reg);

endmodule

`default_nettype wire

// ===== sv/cli_session_cam.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cli_session_cam
    import cli_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step,
    input  wire cli_snap_t   snap,
    input  wire logic [1:0]  alarm_report,
    input  wire logic        plate_seen,
    output      sess_state_t state_next,
    output      sess_event_t event_code,
    output      alarm_t      alarm_next
);

    sess_state_t state_reg;
    alarm_t      alarm_reg;
    logic        last_one_reg;
    logic        have_prev_reg;
    logic        fall_edge;
    alarm_t      alarm_mid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= SESS_IDLE;
            alarm_reg     <= ALM_NONE;
            last_one_reg  <= 1'b0;
            have_prev_reg <= 1'b0;
        end else if (step) begin
            state_reg     <= state_next;
            alarm_reg     <= alarm_next;
            last_one_reg  <= snap.landed_one;
            have_prev_reg <= 1'b1;
        end
    end

    assign fall_edge = have_prev_reg && last_one_reg && snap.landed_zero;
    // A fresh report replaces the held alarm before the machine looks at it.
    assign alarm_mid = (alarm_report != 2'd0) ? alarm_t'(alarm_report) : alarm_reg;

    always_comb begin
        state_next = state_reg;
        alarm_next = alarm_mid;
        event_code = EV_NONE;
        case (state_reg)
            SESS_IDLE: begin
                if (fall_edge && snap.in_zone && snap.lock_one) begin
                    state_next = SESS_DETECT;
                    event_code = EV_BEGIN;
                end
            end
            SESS_DETECT: begin
                if (alarm_mid == ALM_LIFTED || alarm_mid == ALM_DROVE) begin
                    state_next = SESS_LOCK_ALARM;
                    event_code = EV_END_KEEP;
                end else if (plate_seen) begin
                    alarm_next = ALM_NONE;
                    state_next = SESS_LOCK_PLATE;
                    event_code = EV_END_DROP;
                end else if (snap.descending) begin
                    alarm_next = ALM_NONE;
                    state_next = SESS_IDLE;
                    event_code = EV_END_DROP;
                end else if (snap.out_hoist) begin
                    alarm_next = ALM_NONE;
                    state_next = SESS_IDLE;
                    event_code = EV_END_KEEP;
                end
            end
            SESS_LOCK_ALARM: begin
                if (snap.reset_one) begin
                    alarm_next = ALM_NONE;
                    state_next = SESS_IDLE;
                end
            end
            SESS_LOCK_PLATE: begin
                if (snap.out_hoist) begin
                    state_next = SESS_IDLE;
                end
            end
            default: begin
                state_next = SESS_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
